@@ rtl/core/free_partition_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Free partition allocator assertion macros
// Shared assertion forms for the allocator checker, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef FREE_PARTITION_ALLOCATOR_ASSERT_SVH
`define FREE_PARTITION_ALLOCATOR_ASSERT_SVH

// Assertion that is off while reset is applied.
`define FPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Free partition allocator package
// Sizes, codes and the command and status types shared by the allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_BITS   = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 1'b1;

    typedef enum logic [1:0] {
        FN_LOAD    = 2'd0,
        FN_ALLOC   = 2'd1,
        FN_RELEASE = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_FINISH,
        ACT_INSERT,
        ACT_REMOVE
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_INSERT,
        S_REMOVE,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
        logic ins;
        logic rem;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        t_act act;
        logic ins_done;
        logic rem_done;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/core/fpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Free partition allocator controller
// Sequences accept, table scan, decision, table shifts and result hand-off.
// ----------------------------------------------------------------------------
module fpa_ctrl import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                case (i_stat.act)
                    ACT_INSERT: n_state = S_INSERT;
                    ACT_REMOVE: n_state = S_REMOVE;
                    default:    n_state = S_RESULT;
                endcase
            end
            S_INSERT: begin
                o_cmd.ins = 1'b1;
                if (i_stat.ins_done) begin
                    n_state = S_RESULT;
                end
            end
            S_REMOVE: begin
                o_cmd.rem = 1'b1;
                if (i_stat.rem_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/fpa_datapath.sv @@
// ----------------------------------------------------------------------------
// Free partition allocator datapath
// Partition table, scan unit, decision logic, shifter and output register.
// ----------------------------------------------------------------------------
module fpa_datapath import fpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_func,
    input  logic [ADDR_BITS-1:0]  i_start,
    input  logic [ADDR_BITS-1:0]  i_len,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [ADDR_BITS-1:0]  o_gstart,
    output logic [ADDR_BITS-1:0]  o_glen
);

    // Table and configuration.
    logic [ADDR_BITS-1:0] r_tab_start [MAX_ENTRIES];
    logic [ADDR_BITS-1:0] r_tab_len   [MAX_ENTRIES];
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_rover;
    logic [15:0]          r_min_split;
    logic                 r_fit_mode;

    // Request and scan state.
    t_func                r_func;
    logic [ADDR_BITS-1:0] r_s;
    logic [ADDR_BITS-1:0] r_len;
    logic [IDX_W-1:0]     r_i;
    logic [CNT_W-1:0]     r_k;
    logic [CNT_W-1:0]     r_j;
    logic [IDX_W-1:0]     r_rm_idx;
    logic                 r_lo_found;
    logic [IDX_W-1:0]     r_lo_idx;
    logic [ADDR_BITS-1:0] r_lo_start;
    logic [ADDR_BITS-1:0] r_lo_len;
    logic                 r_hi_found;
    logic [IDX_W-1:0]     r_hi_idx;
    logic [ADDR_BITS-1:0] r_hi_len;
    logic                 r_sel_found;
    logic [IDX_W-1:0]     r_sel_idx;
    logic [ADDR_BITS-1:0] r_sel_start;
    logic [ADDR_BITS-1:0] r_sel_len;
    logic                 r_pos_found;
    logic [CNT_W-1:0]     r_pos;

    // Result and output register.
    t_status              r_res_status;
    logic [ADDR_BITS-1:0] r_res_gs;
    logic [ADDR_BITS-1:0] r_res_gl;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [ADDR_BITS-1:0] r_out_gs;
    logic [ADDR_BITS-1:0] r_out_gl;

    // Single table read port.
    logic [IDX_W-1:0]     rd_idx;
    logic [ADDR_BITS-1:0] rd_start;
    logic [ADDR_BITS-1:0] rd_len;

    always_comb begin
        if (i_cmd.ins) begin
            rd_idx = IDX_W'(r_j - 1'b1);
        end else if (i_cmd.rem) begin
            rd_idx = IDX_W'(r_j + 1'b1);
        end else begin
            rd_idx = r_i;
        end
    end

    assign rd_start = r_tab_start[rd_idx];
    assign rd_len   = r_tab_len[rd_idx];

    // Per-entry scan tests, sums compared without wrap.
    logic             lo_hit;
    logic             hi_hit;
    logic             gt_hit;
    logic             fit_hit;
    logic             sel_upd;
    logic             scan_done;
    logic [IDX_W-1:0] i_next;

    assign lo_hit  = ({1'b0, rd_start} + {1'b0, rd_len}) == {1'b0, r_s};
    assign hi_hit  = ({1'b0, r_s} + {1'b0, r_len}) == {1'b0, rd_start};
    assign gt_hit  = rd_start > r_s;
    assign fit_hit = rd_len >= r_len;
    assign sel_upd = fit_hit && (r_fit_mode ? (!r_sel_found || rd_len < r_sel_len)
                                            : !r_sel_found);
    assign scan_done = (r_k == r_count);
    assign i_next    = ((CNT_W'(r_i) + 1'b1) >= r_count) ? '0 : IDX_W'(r_i + 1'b1);

    // Decision on the scan results.
    logic [ADDR_BITS:0]   sum_lo;
    logic [ADDR_BITS:0]   sum_hi;
    logic [ADDR_BITS+1:0] sum_all;
    logic [ADDR_BITS-1:0] rem_len;
    logic                 tab_full;
    t_act                 d_act;
    t_status              d_status;
    logic [ADDR_BITS-1:0] d_gs;
    logic [ADDR_BITS-1:0] d_gl;
    logic                 d_we;
    logic [IDX_W-1:0]     d_widx;
    logic [ADDR_BITS-1:0] d_wstart;
    logic [ADDR_BITS-1:0] d_wlen;
    logic                 d_rover_set;
    logic [IDX_W-1:0]     d_rm_idx;

    assign sum_lo   = {1'b0, r_lo_len} + {1'b0, r_len};
    assign sum_hi   = {1'b0, r_hi_len} + {1'b0, r_len};
    assign sum_all  = {2'b00, r_lo_len} + {2'b00, r_len} + {2'b00, r_hi_len};
    assign rem_len  = r_sel_len - r_len;
    assign tab_full = r_count >= CNT_W'(MAX_ENTRIES);

    always_comb begin
        d_act       = ACT_FINISH;
        d_status    = ST_DONE;
        d_gs        = '0;
        d_gl        = '0;
        d_we        = 1'b0;
        d_widx      = r_lo_idx;
        d_wstart    = r_lo_start;
        d_wlen      = ADDR_BITS'(sum_lo);
        d_rover_set = 1'b0;
        d_rm_idx    = r_sel_idx;
        case (r_func)
            FN_LOAD: begin
                if (r_len != '0) begin
                    if (tab_full) begin
                        d_status = ST_FULL;
                    end else begin
                        d_act = ACT_INSERT;
                    end
                end
            end
            FN_RELEASE: begin
                if (r_len != '0) begin
                    if (r_lo_found && r_hi_found && r_lo_idx != r_hi_idx &&
                        sum_all[ADDR_BITS+1:ADDR_BITS] == 2'b00) begin
                        // Both neighbors join into the lower entry.
                        d_we     = 1'b1;
                        d_wlen   = ADDR_BITS'(sum_all);
                        d_act    = ACT_REMOVE;
                        d_rm_idx = r_hi_idx;
                    end else if (r_lo_found && !sum_lo[ADDR_BITS]) begin
                        d_we = 1'b1;
                    end else if (r_hi_found && !sum_hi[ADDR_BITS]) begin
                        d_we     = 1'b1;
                        d_widx   = r_hi_idx;
                        d_wstart = r_s;
                        d_wlen   = ADDR_BITS'(sum_hi);
                    end else if (tab_full) begin
                        d_status = ST_FULL;
                    end else begin
                        d_act = ACT_INSERT;
                    end
                end
            end
            FN_ALLOC: begin
                if (r_len == '0 || !r_sel_found) begin
                    d_status = ST_NO_FIT;
                end else begin
                    d_gs        = r_sel_start;
                    d_rover_set = !r_fit_mode;
                    if (rem_len > r_min_split) begin
                        // Grant the low part and shrink the entry.
                        d_gl     = r_len;
                        d_we     = 1'b1;
                        d_widx   = r_sel_idx;
                        d_wstart = r_sel_start + r_len;
                        d_wlen   = rem_len;
                    end else begin
                        d_gl  = r_sel_len;
                        d_act = ACT_REMOVE;
                    end
                end
            end
            default: begin
                d_act = ACT_FINISH;
            end
        endcase
    end

    // Shift termination and final count and rover values.
    logic             ins_done;
    logic             rem_done;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] rv_inc;
    logic [CNT_W-1:0] rv_dec;
    logic [IDX_W-1:0] rover_ins;
    logic [IDX_W-1:0] rover_rem;

    assign ins_done = (r_j == r_pos);
    assign rem_done = ((r_j + 1'b1) >= r_count);
    assign cnt_inc  = r_count + 1'b1;
    assign cnt_dec  = r_count - 1'b1;
    assign rv_inc   = (cnt_inc > CNT_W'(1) && CNT_W'(r_rover) >= r_pos) ?
                      CNT_W'(r_rover) + 1'b1 : CNT_W'(r_rover);
    assign rv_dec   = (r_rover > r_rm_idx) ? CNT_W'(r_rover) - 1'b1 : CNT_W'(r_rover);
    assign rover_ins = (rv_inc >= cnt_inc) ? '0 : IDX_W'(rv_inc);
    assign rover_rem = (rv_dec >= cnt_dec) ? '0 : IDX_W'(rv_dec);

    // Table write port.
    logic                 we;
    logic [IDX_W-1:0]     widx;
    logic [ADDR_BITS-1:0] wstart;
    logic [ADDR_BITS-1:0] wlen;

    always_comb begin
        we     = 1'b0;
        widx   = IDX_W'(r_j);
        wstart = rd_start;
        wlen   = rd_len;
        if (i_cmd.decide) begin
            we     = d_we;
            widx   = d_widx;
            wstart = d_wstart;
            wlen   = d_wlen;
        end else if (i_cmd.ins) begin
            we = 1'b1;
            if (ins_done) begin
                widx   = IDX_W'(r_pos);
                wstart = r_s;
                wlen   = r_len;
            end
        end else if (i_cmd.rem) begin
            we = !rem_done;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.scan_done = scan_done;
        o_stat.act       = d_act;
        o_stat.ins_done  = ins_done;
        o_stat.rem_done  = rem_done;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rover     <= '0;
            r_min_split <= '0;
            r_fit_mode  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_SPLIT: r_min_split <= i_cfg_data;
                    CFG_FIT_MODE:  r_fit_mode  <= i_cfg_data[0];
                    default:       r_min_split <= r_min_split;
                endcase
            end
            if (i_cmd.start && t_func'(i_func) == FN_ALLOC && !r_fit_mode &&
                CNT_W'(r_rover) >= r_count) begin
                r_rover <= '0;
            end
            if (i_cmd.decide && d_rover_set) begin
                r_rover <= r_sel_idx;
            end
            if (i_cmd.ins && ins_done) begin
                r_count <= cnt_inc;
                r_rover <= rover_ins;
            end
            if (i_cmd.rem && rem_done) begin
                r_count <= cnt_dec;
                r_rover <= rover_rem;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: request capture, scan capture, shifts, table, output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func      <= t_func'(i_func);
            r_s         <= i_start;
            r_len       <= i_len;
            r_k         <= '0;
            r_lo_found  <= 1'b0;
            r_hi_found  <= 1'b0;
            r_sel_found <= 1'b0;
            r_pos_found <= 1'b0;
            r_pos       <= r_count;
            if (t_func'(i_func) == FN_ALLOC && !r_fit_mode &&
                CNT_W'(r_rover) < r_count) begin
                r_i <= r_rover;
            end else begin
                r_i <= '0;
            end
        end
        if (i_cmd.scan && !scan_done) begin
            r_k <= r_k + 1'b1;
            r_i <= i_next;
            if (lo_hit && !r_lo_found) begin
                r_lo_found <= 1'b1;
                r_lo_idx   <= r_i;
                r_lo_start <= rd_start;
                r_lo_len   <= rd_len;
            end
            if (hi_hit && !r_hi_found) begin
                r_hi_found <= 1'b1;
                r_hi_idx   <= r_i;
                r_hi_len   <= rd_len;
            end
            if (gt_hit && !r_pos_found) begin
                r_pos_found <= 1'b1;
                r_pos       <= CNT_W'(r_i);
            end
            if (sel_upd) begin
                r_sel_found <= 1'b1;
                r_sel_idx   <= r_i;
                r_sel_start <= rd_start;
                r_sel_len   <= rd_len;
            end
        end
        if (i_cmd.decide) begin
            r_res_status <= d_status;
            r_res_gs     <= d_gs;
            r_res_gl     <= d_gl;
            r_rm_idx     <= d_rm_idx;
            r_j          <= (d_act == ACT_INSERT) ? r_count : CNT_W'(d_rm_idx);
        end
        if (i_cmd.ins && !ins_done) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.rem && !rem_done) begin
            r_j <= r_j + 1'b1;
        end
        if (we) begin
            r_tab_start[widx] <= wstart;
            r_tab_len[widx]   <= wlen;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_gs     <= r_res_gs;
            r_out_gl     <= r_res_gl;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_gstart    = r_out_gs;
    assign o_glen      = r_out_gl;

endmodule

@@ rtl/core/free_partition_allocator.sv @@
// Sequence: an accepted beat is followed by a scan of all N entries, where N is the entry count,
// a decision, an insert or remove shift of the table when an entry is added or taken out, and
// the result beat, which waits while the receiver stalls the output.
// Flow: one request at a time; a new beat is taken only once the last result has been loaded
// into the output register. The scan and the shifts share the single table read port.
// Reset: synchronous active low; clears entry count, rover, configuration and the output.
// ----------------------------------------------------------------------------
// Free partition allocator
// Address-ordered free partition table with next-fit and best-fit allocation.
// ----------------------------------------------------------------------------
module free_partition_allocator import fpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // start_addr[15:0], length[31:16]
    input  logic [1:0]            s_axis_tuser,   // func[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // granted_start[15:0], granted_length[31:16]
    output logic [1:0]            m_axis_tuser    // status[1:0]
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table and arithmetic.
    fpa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser),
        .i_start     (s_axis_tdata[15:0]),
        .i_len       (s_axis_tdata[31:16]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_gstart    (m_axis_tdata[15:0]),
        .o_glen      (m_axis_tdata[31:16])
    );

endmodule

@@ rtl/core/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// Free partition allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "free_partition_allocator_assert.svh"

module fpa_checker import fpa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [31:0]           s_axis_tdata,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [31:0]           m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    // A stalled result beat holds its payload.
    `FPA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // The output is empty after reset.
    `FPA_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // Only one request is in work: ready drops after an accepted beat.
    `FPA_ASSERT(a_one_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request taken")

    // Failed requests grant nothing.
    `FPA_ASSERT(a_fail_zero, m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == 32'd0, "grant on failure")

    // Status is one of the defined codes.
    `FPA_ASSERT(a_status_code, m_axis_tvalid |-> m_axis_tuser != 2'd3, "bad status code")

endmodule

bind free_partition_allocator fpa_checker u_fpa_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Free partition allocator testbench
// Drives load, allocate and release beats under both search policies and
// several split thresholds, predicts every response from a behavioral copy
// of the partition table and checks each response beat field by field.
// ----------------------------------------------------------------------------
module testbench;
    import fpa_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // start_addr[15:0], length[31:16]
    logic [1:0]            s_axis_tuser;   // func[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // granted_start[15:0], granted_length[31:16]
    logic [1:0]            m_axis_tuser;   // status[1:0]

    localparam int LATENCY_CYCLES = 40;
    localparam int STALL_LIMIT    = 20000;

    typedef struct packed {
        t_status     status;
        logic [15:0] gstart;
        logic [15:0] glen;
    } t_grant;

    // Predicted partition table and configuration.
    logic [15:0] tbl_start [MAX_ENTRIES];
    logic [15:0] tbl_len   [MAX_ENTRIES];
    int          tbl_count;
    int          rover_idx;
    logic [15:0] split_thr;
    logic        best_fit;

    t_grant      expected_grants[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    int          quiet_cycles;
    bit          stim_done;

    free_partition_allocator DUT (.*);

    // Clock.
    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // Table maintenance for the predictor.
    function automatic void tbl_wrap_rover();
        if (rover_idx >= tbl_count) rover_idx = 0;
    endfunction

    function automatic void tbl_remove(int idx);
        for (int j = idx; j + 1 < tbl_count; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_len[j]   = tbl_len[j+1];
        end
        tbl_count--;
        if (rover_idx > idx) rover_idx--;
        tbl_wrap_rover();
    endfunction

    function automatic void tbl_insert(logic [15:0] s, logic [15:0] len);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_start[pos] <= s) pos++;
        for (int j = tbl_count; j > pos; j--) begin
            tbl_start[j] = tbl_start[j-1];
            tbl_len[j]   = tbl_len[j-1];
        end
        tbl_start[pos] = s;
        tbl_len[pos]   = len;
        tbl_count++;
        if (tbl_count > 1 && rover_idx >= pos) rover_idx++;
        tbl_wrap_rover();
    endfunction

    function automatic t_status tbl_release(logic [15:0] s, logic [15:0] len);
        bit has_lo, has_hi;
        int lo, hi;
        has_lo = 0; has_hi = 0; lo = 0; hi = 0;
        for (int i = 0; i < tbl_count; i++) begin
            if (!has_lo && 17'(tbl_start[i]) + 17'(tbl_len[i]) == 17'(s)) begin
                has_lo = 1; lo = i;
            end
            if (!has_hi && 17'(s) + 17'(len) == 17'(tbl_start[i])) begin
                has_hi = 1; hi = i;
            end
        end
        if (has_lo && has_hi && lo != hi &&
            18'(tbl_len[lo]) + 18'(len) + 18'(tbl_len[hi]) <= 18'hFFFF) begin
            tbl_len[lo] = tbl_len[lo] + len + tbl_len[hi];
            tbl_remove(hi);
            return ST_DONE;
        end
        if (has_lo && 17'(tbl_len[lo]) + 17'(len) <= 17'hFFFF) begin
            tbl_len[lo] += len;
            return ST_DONE;
        end
        if (has_hi && 17'(tbl_len[hi]) + 17'(len) <= 17'hFFFF) begin
            tbl_start[hi] = s;
            tbl_len[hi]  += len;
            return ST_DONE;
        end
        if (tbl_count >= MAX_ENTRIES) return ST_FULL;
        tbl_insert(s, len);
        return ST_DONE;
    endfunction

    // Computes the response to one request and updates the table.
    function automatic t_grant predict_grant(t_func fn, logic [15:0] s, logic [15:0] len);
        t_grant g;
        bit     found;
        int     sel, i;
        g = '{ST_DONE, 16'd0, 16'd0};
        found = 0; sel = 0;
        case (fn)
            FN_LOAD: begin
                if (len != 0) begin
                    if (tbl_count >= MAX_ENTRIES) g.status = ST_FULL;
                    else tbl_insert(s, len);
                end
            end
            FN_RELEASE: begin
                if (len != 0) g.status = tbl_release(s, len);
            end
            FN_ALLOC: begin
                if (len != 0) begin
                    if (!best_fit) begin
                        tbl_wrap_rover();
                        i = rover_idx;
                        for (int k = 0; k < tbl_count; k++) begin
                            if (tbl_len[i] >= len) begin
                                found = 1; sel = i; break;
                            end
                            i++;
                            if (i >= tbl_count) i = 0;
                        end
                    end else begin
                        for (i = 0; i < tbl_count; i++) begin
                            if (tbl_len[i] >= len && (!found || tbl_len[i] < tbl_len[sel])) begin
                                found = 1; sel = i;
                            end
                        end
                    end
                end
                if (!found) begin
                    g.status = ST_NO_FIT;
                end else begin
                    g.gstart = tbl_start[sel];
                    if (tbl_len[sel] - len > split_thr) begin
                        g.glen = len;
                        tbl_start[sel] += len;
                        tbl_len[sel]   -= len;
                        if (!best_fit) rover_idx = sel;
                    end else begin
                        g.glen = tbl_len[sel];
                        if (!best_fit) rover_idx = sel;
                        tbl_remove(sel);
                    end
                    tbl_wrap_rover();
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Sends one request beat, idling beforehand at random. Valid stays high
    // after the accepting edge until the next beat or an idle cycle replaces it.
    task automatic send_request(t_func fn, logic [15:0] s, logic [15:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {len, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_grants.push_back(predict_grant(fn, s, len));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MIN_SPLIT) split_thr = val;
        else best_fit = val[0];
    endtask

    // Response checker.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch("unexpected beat count", 1, 0);
            end else begin
                want = expected_grants.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[15:0] != want.gstart)
                    report_mismatch("granted_start", m_axis_tdata[15:0], want.gstart);
                if (m_axis_tdata[31:16] != want.glen)
                    report_mismatch("granted_length", m_axis_tdata[31:16], want.glen);
            end
        end
    end

    // Receiver ready, with random idling and an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Random span with mostly small lengths and occasional extremes.
    function automatic logic [15:0] pick_len();
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic test_directed();
        send_request(FN_ALLOC, 16'h0000, 16'd5);        // empty table: no fit
        send_request(FN_LOAD, 16'h1000, 16'd0);         // zero length load
        send_request(FN_NONE, 16'hFFFF, 16'hFFFF);      // unknown operation
        send_request(FN_LOAD, 16'h1000, 16'd100);
        send_request(FN_LOAD, 16'h0000, 16'd50);
        send_request(FN_LOAD, 16'hFFF0, 16'hFFFF);      // extremes of both fields
        send_request(FN_ALLOC, 16'h0000, 16'd0);        // zero length allocate
        send_request(FN_ALLOC, 16'h0000, 16'd10);
        send_request(FN_ALLOC, 16'h0000, 16'd90);       // split of a larger entry
        send_request(FN_ALLOC, 16'h0000, 16'hFFFF);     // whole entry taken, span wraps past the top
        send_request(FN_RELEASE, 16'h1000, 16'd0);      // zero length release
        send_request(FN_RELEASE, 16'h1000, 16'd10);     // merge with neither
        send_request(FN_RELEASE, 16'h100A, 16'd90);     // merge below
        send_request(FN_RELEASE, 16'h0FF0, 16'd16);     // merge above
        send_request(FN_RELEASE, 16'h0032, 16'h0FBE);   // merge both sides
        send_request(FN_RELEASE, 16'h0000, 16'hFFFF);   // full-range span, merge with neither
        send_request(FN_LOAD, 16'h1000, 16'd7);         // insert between entries
        for (int i = 0; i < 16; i++)                    // fill the table
            send_request(FN_LOAD, 16'(i * 16'h0200 + 16'h4000), 16'd4);
        send_request(FN_RELEASE, 16'h8000, 16'd3);      // full table
    endtask

    // Random mix of requests under the current settings.
    task automatic test_random(int n);
        t_func fn;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: fn = FN_LOAD;
                3, 4, 5, 6: fn = FN_ALLOC;
                9: fn = ($urandom_range(3) == 0) ? FN_NONE : FN_RELEASE;
                default: fn = FN_RELEASE;
            endcase
            send_request(fn, 16'($urandom_range(0, 63) * 64), pick_len());
        end
    endtask

    // Receiver holds off while requests keep coming, then the sender pauses.
    task automatic test_back_pressure();
        hold_off_cycles = 400;
        test_random(20);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_addr = CFG_MIN_SPLIT; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = FN_LOAD;
        m_axis_tready = 1'b0;
        error_count = 0; hold_off_cycles = 0; quiet_cycles = 0; stim_done = 0;
        tbl_count = 0; rover_idx = 0; split_thr = '0; best_fit = 1'b0;
        send_idle_pct = 30; recv_idle_pct = 84;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_reg(CFG_FIT_MODE, 16'd1);
        test_directed();
        test_back_pressure();
        test_random(150);
        send_idle_pct = 84; recv_idle_pct = 30;
        write_reg(CFG_MIN_SPLIT, 16'hFFFF);
        test_random(120);
        write_reg(CFG_FIT_MODE, 16'd0);
        test_random(120);
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_MIN_SPLIT, 16'd8);
        test_random(120);
        write_reg(CFG_FIT_MODE, 16'd1);
        write_reg(CFG_MIN_SPLIT, 16'd0);
        test_random(120);

        wait_drained();
        stim_done = 1;
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_ctrl.sv
rtl/core/fpa_datapath.sv
rtl/core/free_partition_allocator.sv
rtl/core/fpa_checker.sv
tb/sv/testbench.sv
